### design/speech_gain_soft_limiter_assert.svh
// ----------------------------------------------------------------------------
// speech_gain_soft_limiter assertion macros
// Concurrent assertion helpers, clocked on clk and disabled under arst_n.
// ----------------------------------------------------------------------------
`ifndef SPEECH_GAIN_SOFT_LIMITER_ASSERT_SVH
`define SPEECH_GAIN_SOFT_LIMITER_ASSERT_SVH

// same-cycle implication
`define SGSL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SGSL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sgsl_pkg.sv
// ----------------------------------------------------------------------------
// sgsl_pkg
// Types, constants and the gain table of the speech gain soft limiter.
// ----------------------------------------------------------------------------
package sgsl_pkg;

	localparam int MAG_W   = 16;  // |sample|, up to 32768
	localparam int AMP_W   = 17;  // amplified magnitude
	localparam int GAIN_W  = 18;  // Q16 gain
	localparam int PROD_W  = AMP_W + GAIN_W;
	localparam int OUT_W   = 15;  // limited magnitude
	localparam int NUM_W   = 29;  // headroom * excess
	localparam int DEN_W   = 17;  // excess + headroom
	localparam int QUO_W   = 12;  // quotient stays below headroom
	localparam int GDB_W   = 4;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [AMP_W-1:0]  KNEE       = AMP_W'(29490);
	localparam logic [AMP_W-1:0]  FULL_SCALE = AMP_W'(32767);
	localparam logic [AMP_W-1:0]  HEADROOM   = FULL_SCALE - KNEE;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
	localparam int                FRAC_W     = 16;
	localparam logic [GDB_W-1:0]  GAIN_MAX_DB = GDB_W'(12);

	typedef struct packed {
		logic signed [15:0] sample_in;
		logic               frame_last;
	} sgsl_in_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [15:0]        input_peak;
		logic [16:0]        pre_limit_peak;
		logic [14:0]        final_peak;
		logic [15:0]        overrange_count;
		logic [15:0]        limited_count;
		logic [15:0]        processed_count;
		logic               frame_done;
	} sgsl_out_t;

	typedef struct packed {
		logic [GDB_W-1:0] gain_db;
	} sgsl_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sgsl_div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_AMP,
		ST_CHK,
		ST_NUM,
		ST_DIVS,
		ST_DIV,
		ST_DONE
	} sgsl_state_t;

	// Q16 gain for 0..12 dB, codes above 12 saturate
	function automatic logic [GAIN_W-1:0] gain_lookup(input logic [GDB_W-1:0] db);
		logic [GAIN_W-1:0] g;
		unique case (db)
			4'd0:    g = GAIN_W'(65536);
			4'd1:    g = GAIN_W'(73533);
			4'd2:    g = GAIN_W'(82505);
			4'd3:    g = GAIN_W'(92572);
			4'd4:    g = GAIN_W'(103868);
			4'd5:    g = GAIN_W'(116541);
			4'd6:    g = GAIN_W'(130762);
			4'd7:    g = GAIN_W'(146717);
			4'd8:    g = GAIN_W'(164619);
			4'd9:    g = GAIN_W'(184706);
			4'd10:   g = GAIN_W'(207243);
			4'd11:   g = GAIN_W'(232531);
			default: g = GAIN_W'(260904);
		endcase
		return g;
	endfunction

endpackage

### design/sgsl_stream_if.sv
// ----------------------------------------------------------------------------
// sgsl_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface sgsl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/sgsl_div.sv
// ----------------------------------------------------------------------------
// sgsl_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUO_W.
// ----------------------------------------------------------------------------
module sgsl_div
	import sgsl_pkg::*;
#(
	parameter int N_W = NUM_W,
	parameter int D_W = DEN_W,
	parameter int Q_W = QUO_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [Q_W-1:0] quotient,
	output sgsl_div_stat_t stat
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [Q_W-1:0]   shift_q;   // numerator low bits in, quotient bits out
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0] cat;
	logic [D_W:0] diff;
	logic         ge;

	assign cat  = {rem_q, shift_q[Q_W-1]};
	assign ge   = cat >= {1'b0, den_q};
	assign diff = cat - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= D_W'(num[N_W-1:Q_W]);
			shift_q <= num[Q_W-1:0];
			den_q   <= den;
		end else if (busy_q) begin
			rem_q   <= ge ? diff[D_W-1:0] : cat[D_W-1:0];
			shift_q <= {shift_q[Q_W-2:0], ge};
		end
	end

	assign quotient  = shift_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

### design/speech_gain_soft_limiter.sv
// ----------------------------------------------------------------------------
// speech_gain_soft_limiter
// Digital gain of 0..12 dB with a soft knee limiter and per-frame metrics.
// ----------------------------------------------------------------------------
// Channels: samples (sink) takes one PCM sample and frame_last per beat;
//   results (source) gives the limited sample and the running frame metrics,
//   one beat per sample; cfg writes gain_db, always ready, write only idle.
// Timing: the shared multiplier forms magnitude * gain, the sum is rounded
//   and checked against the knee. Below it the rounded value goes to the
//   result register. Above it the multiplier forms headroom * excess and
//   the 12-step serial divider yields the compressed part, which is added
//   to the knee. samples.ready is high only while the sequencer idles.
// Reset: gain_db returns to 0 dB, metrics clear, no result pending.
// Stall: the result register holds its beat until taken; the next sample is
//   accepted meanwhile, and its result waits in the last step.
// Metrics clear after the beat that carries frame_done.
// ----------------------------------------------------------------------------
`include "speech_gain_soft_limiter_assert.svh"

module speech_gain_soft_limiter
	import sgsl_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	sgsl_stream_if.sink   cfg,
	sgsl_stream_if.sink   samples,
	sgsl_stream_if.source results
);
	localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	sgsl_state_t state_q, state_n;

	// configuration
	logic [GDB_W-1:0] gain_db_q;

	// item registers
	logic signed [15:0] sample_q;
	logic               last_q;
	logic [MAG_W-1:0]   in_mag_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AMP_W-1:0]   amp_q;
	logic [AMP_W-1:0]   excess_q;
	logic [OUT_W-1:0]   out_mag_q;
	logic               over_q;
	logic               lim_q;

	// frame metrics
	logic [15:0]            src_peak_q;
	logic [AMP_W-1:0]       pre_peak_q;
	logic [OUT_W-1:0]       out_peak_q;
	logic [COUNT_WIDTH-1:0] over_cnt_q;
	logic [COUNT_WIDTH-1:0] lim_cnt_q;
	logic [COUNT_WIDTH-1:0] proc_cnt_q;

	// result register
	sgsl_out_t out_q;
	logic      out_valid_q;

	// sequencer controls
	logic accept;
	logic mul_excess;  // 0: magnitude * gain, 1: excess * headroom
	logic div_start;
	logic out_load;

	// shared multiplier
	logic [AMP_W-1:0]  mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_p;

	logic [PROD_W-1:0] amp_sum;
	logic [MAG_W-1:0]  in_mag;
	logic [GDB_W-1:0]  gain_sel;

	logic [QUO_W-1:0] quotient;
	sgsl_div_stat_t   div_stat;
	logic [DEN_W-1:0] div_den;

	// next metrics
	logic [15:0]            src_peak_n;
	logic [AMP_W-1:0]       pre_peak_n;
	logic [OUT_W-1:0]       out_peak_n;
	logic [COUNT_WIDTH-1:0] over_cnt_n;
	logic [COUNT_WIDTH-1:0] lim_cnt_n;
	logic [COUNT_WIDTH-1:0] proc_cnt_n;
	logic [EXT_W-1:0]       over_ext;
	logic [EXT_W-1:0]       lim_ext;
	logic [EXT_W-1:0]       proc_ext;
	logic [15:0]            neg_mag;

	function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + COUNT_WIDTH'(1);
	endfunction

	// --- configuration ------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_db_q <= '0;
		end else if (cfg.valid) begin
			gain_db_q <= cfg.data.gain_db;
		end
	end

	// --- input side ---------------------------------------------------------
	// two's complement magnitude; -32768 gives 0x8000
	assign in_mag   = samples.data.sample_in[15] ? MAG_W'(-samples.data.sample_in)
	                                             : MAG_W'(samples.data.sample_in);
	assign gain_sel = (gain_db_q > GAIN_MAX_DB) ? GAIN_MAX_DB : gain_db_q;
	assign accept   = samples.valid && samples.ready;

	// --- shared multiplier --------------------------------------------------
	assign mul_a = mul_excess ? excess_q : AMP_W'(in_mag_q);
	assign mul_b = mul_excess ? GAIN_W'(HEADROOM) : gain_q;
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// round half up on the magnitude, i.e. half away from zero on the value
	assign amp_sum = prod_q + ROUND_HALF;
	assign div_den = DEN_W'(excess_q + HEADROOM);

	sgsl_div #(
		.N_W (NUM_W),
		.D_W (DEN_W),
		.Q_W (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (prod_q[NUM_W-1:0]),
		.den      (div_den),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// --- sequencer ----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		samples.ready = 1'b0;
		mul_excess    = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) state_n = ST_MUL;
			end
			ST_MUL:  state_n = ST_AMP;
			ST_AMP:  state_n = ST_CHK;
			ST_CHK: begin
				state_n = (amp_q > KNEE) ? ST_NUM : ST_DONE;
			end
			ST_NUM: begin
				mul_excess = 1'b1;
				state_n    = ST_DIVS;
			end
			ST_DIVS: begin
				div_start = 1'b1;
				state_n   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
		endcase
	end

	// --- datapath registers -------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.data.sample_in;
			last_q   <= samples.data.frame_last;
			in_mag_q <= in_mag;
			gain_q   <= gain_lookup(gain_sel);
		end
		if (state_q == ST_MUL || state_q == ST_NUM) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_AMP) begin
			amp_q <= amp_sum[FRAC_W+AMP_W-1:FRAC_W];
		end
		if (state_q == ST_CHK) begin
			over_q    <= amp_q > FULL_SCALE;
			lim_q     <= amp_q > KNEE;
			excess_q  <= amp_q - KNEE;
			out_mag_q <= amp_q[OUT_W-1:0];  // kept only below the knee
		end
		if (state_q == ST_DIV && div_stat.done) begin
			out_mag_q <= OUT_W'(KNEE) + OUT_W'(quotient);
		end
	end

	// --- metrics ------------------------------------------------------------
	assign src_peak_n = (in_mag_q > src_peak_q) ? in_mag_q : src_peak_q;
	assign pre_peak_n = (amp_q > pre_peak_q) ? amp_q : pre_peak_q;
	assign out_peak_n = (out_mag_q > out_peak_q) ? out_mag_q : out_peak_q;
	assign over_cnt_n = over_q ? count_up(over_cnt_q) : over_cnt_q;
	assign lim_cnt_n  = lim_q ? count_up(lim_cnt_q) : lim_cnt_q;
	assign proc_cnt_n = count_up(proc_cnt_q);
	assign over_ext   = EXT_W'(over_cnt_n);
	assign lim_ext    = EXT_W'(lim_cnt_n);
	assign proc_ext   = EXT_W'(proc_cnt_n);
	assign neg_mag    = 16'(-{1'b0, out_mag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_peak_q <= '0;
			pre_peak_q <= '0;
			out_peak_q <= '0;
			over_cnt_q <= '0;
			lim_cnt_q  <= '0;
			proc_cnt_q <= '0;
		end else if (out_load) begin
			if (last_q) begin
				src_peak_q <= '0;
				pre_peak_q <= '0;
				out_peak_q <= '0;
				over_cnt_q <= '0;
				lim_cnt_q  <= '0;
				proc_cnt_q <= '0;
			end else begin
				src_peak_q <= src_peak_n;
				pre_peak_q <= pre_peak_n;
				out_peak_q <= out_peak_n;
				over_cnt_q <= over_cnt_n;
				lim_cnt_q  <= lim_cnt_n;
				proc_cnt_q <= proc_cnt_n;
			end
		end
	end

	// --- result register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// zero keeps no sign
			out_q.sample_out      <= (sample_q[15] && out_mag_q != '0) ? neg_mag
			                                                          : 16'(out_mag_q);
			out_q.input_peak      <= src_peak_n;
			out_q.pre_limit_peak  <= pre_peak_n;
			out_q.final_peak      <= out_peak_n;
			out_q.overrange_count <= over_ext[15:0];
			out_q.limited_count   <= lim_ext[15:0];
			out_q.processed_count <= proc_ext[15:0];
			out_q.frame_done      <= last_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// --- assertions ---------------------------------------------------------
	`SGSL_ASSERT_NXT(a_accept_starts_mul, samples.valid && samples.ready,
		state_q == ST_MUL, "accepted beat did not start the multiply")
	`SGSL_ASSERT_IMP(a_quotient_bound, state_q == ST_DIV && div_stat.done,
		quotient < QUO_W'(HEADROOM), "limiter quotient reached headroom")
	`SGSL_ASSERT_NXT(a_frame_clear, out_load && last_q,
		proc_cnt_q == '0 && src_peak_q == '0, "metrics not cleared after frame end")
endmodule
